// ===== sv/hufd_pkg.sv =====
`default_nettype none
package hufd_pkg;

  localparam int unsigned MAX_SYMBOLS_DEF = 128;

  localparam logic [7:0] CH_ONE  = 8'h31;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NL   = 8'h0A;

  localparam logic [1:0] KIND_SYMBOL     = 2'd0;
  localparam logic [1:0] KIND_NO_NEWLINE = 2'd1;
  localparam logic [1:0] KIND_BAD_TREE   = 2'd2;

  // One entry of the node table.
  typedef struct packed {
    logic       leaf;
    logic [7:0] sym;
    logic [7:0] left;
    logic [7:0] right;
  } node_ent_t;

endpackage
`default_nettype wire

// ===== sv/huffman_tree_load_and_decode.sv =====
// An input byte is registered into byte_r, and its result beat is then registered onto out_valid.
// No new byte is taken while the last one is worked on or a result is stalled.
// The node table read (next node in decode) and the subtree stack read (merge) are both registered.
// Reset is synchronous on rst_n (active low) and clears the phase, counters, busy and out_valid.
// The node table and the subtree stack are not cleared; entries are written before use.
`default_nettype none
module huffman_tree_load_and_decode
  import hufd_pkg::*;
#(
  parameter int unsigned MAX_SYMBOLS = MAX_SYMBOLS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_symbol,
  output logic             out_last,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // The node table never needs more than two entries per leaf, minus one.
  localparam int unsigned NODE_CAP = (2 * MAX_SYMBOLS - 1) > 256 ? 256 : (2 * MAX_SYMBOLS - 1);
  localparam int unsigned NAW = $clog2(NODE_CAP);
  localparam int unsigned CW  = $clog2(NODE_CAP + 1);
  localparam int unsigned SW  = $clog2(MAX_SYMBOLS);
  localparam int unsigned DW  = $clog2(MAX_SYMBOLS + 1);

  typedef enum logic [5:0] {
    PH_CTRL   = 6'b000001,
    PH_SYM    = 6'b000010,
    PH_NL     = 6'b000100,
    PH_DECODE = 6'b001000,
    PH_DONE   = 6'b010000,
    PH_STOP   = 6'b100000
  } phase_t;

  // Configuration register.
  logic [31:0] symbol_count_r;

  // Control state.
  phase_t      phase_r, phase_nxt;
  logic        busy_r;
  logic [7:0]  byte_r;
  logic [DW-1:0] depth_r, depth_nxt;
  logic [CW-1:0] nodes_r, nodes_nxt;
  logic [8:0]  ones_r, ones_nxt;
  logic [8:0]  zeros_r, zeros_nxt;
  logic [31:0] left_r, left_nxt;

  // The top of the subtree stack is held in a register, together with its node entry,
  // so the memory only holds the subtrees below it. The root entry and the entry of the
  // node the decoder stands on are held too, so each code bit costs a single table read.
  logic [7:0]  top_r, top_nxt;
  node_ent_t   top_ent_r, top_ent_nxt;
  node_ent_t   root_ent_r, root_ent_nxt;
  node_ent_t   cur_ent_r, cur_ent_nxt;

  // Result register.
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_kind_r;
  logic [7:0]  out_symbol_r;
  logic        out_last_r;

  // Memories.
  node_ent_t   node_mem [NODE_CAP];
  logic [7:0]  stk_mem [MAX_SYMBOLS];
  node_ent_t   node_rd_r;
  logic [7:0]  stk_rd_r;

  logic          in_acc;
  logic [7:0]    child;
  logic [DW-1:0] stk_ra_full;
  logic [DW-1:0] stk_wa_full;

  logic          node_we;
  logic [7:0]    node_wa;
  node_ent_t     node_wd;
  logic          stk_we;

  logic          res_v;
  logic [1:0]    res_kind;
  logic [7:0]    res_sym;
  logic          res_last;
  logic          do_end;
  logic          fail;
  logic [7:0]    new_ptr;

  // A byte is taken in one cycle and worked on in the next, while the memories deliver
  // their read data. The result register is always empty in the work cycle because a
  // new beat is only taken when the pending result is free to leave.
  assign in_stall = busy_r | (out_valid_r & out_stall);
  assign in_acc   = in_valid & ~in_stall;

  // Read addresses come from the state at the accept edge.
  assign child       = (in_byte == CH_ZERO) ? cur_ent_r.left : cur_ent_r.right;
  assign stk_ra_full = depth_r - DW'(2);
  assign stk_wa_full = depth_r - DW'(1);
  assign new_ptr     = 8'(nodes_r);

  always_ff @(posedge clk) begin
    if (in_acc) begin
      node_rd_r <= node_mem[child[NAW-1:0]];
      stk_rd_r  <= stk_mem[stk_ra_full[SW-1:0]];
    end
    if (node_we) begin
      node_mem[node_wa[NAW-1:0]] <= node_wd;
    end
    if (stk_we) begin
      stk_mem[stk_wa_full[SW-1:0]] <= top_r;
    end
  end

  always_comb begin
    phase_nxt    = phase_r;
    depth_nxt    = depth_r;
    nodes_nxt    = nodes_r;
    ones_nxt     = ones_r;
    zeros_nxt    = zeros_r;
    left_nxt     = left_r;
    top_nxt      = top_r;
    top_ent_nxt  = top_ent_r;
    root_ent_nxt = root_ent_r;
    cur_ent_nxt  = cur_ent_r;
    node_we      = 1'b0;
    node_wa      = new_ptr;
    node_wd      = '0;
    stk_we       = 1'b0;
    res_v        = 1'b0;
    res_kind     = KIND_SYMBOL;
    res_sym      = 8'd0;
    res_last     = 1'b0;
    do_end       = 1'b0;
    fail         = 1'b0;

    if (busy_r) begin
      unique case (phase_r) inside
        PH_CTRL: begin
          if (byte_r == CH_ONE) begin
            ones_nxt  = ones_r + 9'd1;
            phase_nxt = PH_SYM;
          end else begin
            if (byte_r == CH_ZERO) begin
              if (zeros_r != 9'h1FF) begin
                zeros_nxt = zeros_r + 9'd1;
              end
              // Merge: the older subtree becomes the left child.
              if (depth_r >= DW'(2)) begin
                if (nodes_r >= CW'(NODE_CAP)) begin
                  fail = 1'b1;
                end else begin
                  node_we     = 1'b1;
                  node_wd     = '{leaf: 1'b0, sym: 8'd0, left: stk_rd_r, right: top_r};
                  nodes_nxt   = nodes_r + CW'(1);
                  depth_nxt   = depth_r - DW'(1);
                  top_nxt     = new_ptr;
                  top_ent_nxt = node_wd;
                end
              end
            end
            do_end = ~fail;
          end
        end
        PH_SYM: begin
          if (nodes_r >= CW'(NODE_CAP) || depth_r >= DW'(MAX_SYMBOLS)) begin
            fail = 1'b1;
          end else begin
            node_we     = 1'b1;
            node_wd     = '{leaf: 1'b1, sym: byte_r, left: 8'd0, right: 8'd0};
            stk_we      = (depth_r != '0);
            nodes_nxt   = nodes_r + CW'(1);
            depth_nxt   = depth_r + DW'(1);
            top_nxt     = new_ptr;
            top_ent_nxt = node_wd;
            do_end      = 1'b1;
          end
        end
        PH_NL: begin
          cur_ent_nxt = root_ent_r;
          left_nxt    = symbol_count_r;
          phase_nxt   = (symbol_count_r == 32'd0) ? PH_DONE : PH_DECODE;
          if (byte_r != CH_NL) begin
            res_v    = 1'b1;
            res_kind = KIND_NO_NEWLINE;
          end
        end
        PH_DECODE: begin
          if (byte_r == CH_ZERO || byte_r == CH_ONE) begin
            if (root_ent_r.leaf || node_rd_r.leaf) begin
              res_v       = 1'b1;
              res_sym     = root_ent_r.leaf ? root_ent_r.sym : node_rd_r.sym;
              res_last    = (left_r == 32'd1);
              left_nxt    = left_r - 32'd1;
              cur_ent_nxt = root_ent_r;
              if (left_r == 32'd1) begin
                phase_nxt = PH_DONE;
              end
            end else begin
              cur_ent_nxt = node_rd_r;
            end
          end
        end
        PH_DONE, PH_STOP: begin
        end
        default: begin
        end
      endcase

      // End of header: equal counts of ones and zeros.
      if (do_end) begin
        if (ones_nxt != zeros_nxt) begin
          phase_nxt = PH_CTRL;
        end else if (depth_nxt == '0) begin
          fail = 1'b1;
        end else begin
          root_ent_nxt = top_ent_nxt;
          phase_nxt    = PH_NL;
        end
      end

      if (fail) begin
        phase_nxt = PH_STOP;
        res_v     = 1'b1;
        res_kind  = KIND_BAD_TREE;
        res_sym   = 8'd0;
        res_last  = 1'b0;
      end
    end

    if (busy_r && res_v) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_CTRL;
      busy_r         <= 1'b0;
      depth_r        <= '0;
      nodes_r        <= '0;
      ones_r         <= '0;
      zeros_r        <= '0;
      left_r         <= '0;
      out_valid_r    <= 1'b0;
      symbol_count_r <= '0;
    end else begin
      phase_r     <= phase_nxt;
      busy_r      <= in_acc;
      depth_r     <= depth_nxt;
      nodes_r     <= nodes_nxt;
      ones_r      <= ones_nxt;
      zeros_r     <= zeros_nxt;
      left_r      <= left_nxt;
      out_valid_r <= out_valid_nxt;
      if (psel && penable && pwrite && !paddr[2]) begin
        symbol_count_r <= pwdata;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      byte_r <= in_byte;
    end
    top_r      <= top_nxt;
    top_ent_r  <= top_ent_nxt;
    root_ent_r <= root_ent_nxt;
    cur_ent_r  <= cur_ent_nxt;
    if (busy_r && res_v) begin
      out_kind_r   <= res_kind;
      out_symbol_r <= res_sym;
      out_last_r   <= res_last;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_kind   = out_kind_r;
  assign out_symbol = out_symbol_r;
  assign out_last   = out_last_r;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : symbol_count_r;

endmodule
`default_nettype wire

// ===== sv/hufd_chk.sv =====
`default_nettype none
module hufd_chk
  import hufd_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [1:0] out_kind,
  input wire logic [7:0] out_symbol,
  input wire logic       out_last
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_symbol)
      && $stable(out_last))
    else $error("stalled result beat changed");

  // Every accepted byte is followed by a work cycle in which no byte is taken.
  a_work_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("byte accepted during work cycle");

  // A fresh result is registered in the work cycle of an accepted byte.
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without accepted byte");

  // Error results carry no symbol and never close the count.
  a_error_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_SYMBOL |-> out_symbol == 8'd0 && !out_last
      && (out_kind == KIND_NO_NEWLINE || out_kind == KIND_BAD_TREE))
    else $error("bad error result payload");

endmodule

bind huffman_tree_load_and_decode hufd_chk u_hufd_chk (.*);
`default_nettype wire
